// ----- hw/rtl/pfd_pkg.sv -----
// Package for the pose frame deframer: frame marker bytes, sizes and the
// receive phase type. Used by the deframer and its port checker.
// No dependencies.
package pfd_pkg;

  // Frame markers
  localparam logic [7:0] HDR_FIRST  = 8'h0D;
  localparam logic [7:0] HDR_SECOND = 8'h0A;
  localparam logic [7:0] TRL_FIRST  = 8'h0A;
  localparam logic [7:0] TRL_SECOND = 8'h0D;

  // Frame geometry
  localparam int unsigned PayloadLen = 24;
  localparam int unsigned WordCount  = 6;
  localparam int unsigned WordWidth  = 32;
  localparam int unsigned ByteWidth  = 8;
  localparam int unsigned IdxWidth   = 5;
  localparam int unsigned OutWidth   = WordCount * WordWidth;
  localparam logic [IdxWidth-1:0] LastIdx = IdxWidth'(PayloadLen - 1);

  // Receive phase, one-hot
  typedef enum logic [4:0] {
    PH_HUNT    = 5'b00001,
    PH_HDR     = 5'b00010,
    PH_PAYLOAD = 5'b00100,
    PH_TRL1    = 5'b01000,
    PH_TRL2    = 5'b10000
  } phase_e;

endpackage

// ----- hw/rtl/pose_frame_deframer.sv -----
// Pose frame deframer: hunts 0x0D 0x0A, 24 payload bytes, 0x0A 0x0D and
// emits the payload as six 32-bit little-endian words. Depends on pfd_pkg.
// Throughput: one byte beat per cycle; the input stalls only when a frame's
// final byte arrives while the previous result beat is still held.
// The result beat is registered and valid in the cycle after the final trailer byte.
// Reset (rst_ni low, asynchronous): back to the header hunt, no result held.
module pose_frame_deframer
  import pfd_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // [7:0] rx_byte
  input  logic [7:0]          s_axis_tdata,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // [31:0] yaw_angle_bits, [63:32] roll_angle_bits, [95:64] pitch_angle_bits,
  // [127:96] position_x_bits, [159:128] position_y_bits, [191:160] yaw_rate_bits
  output logic [OutWidth-1:0] m_axis_tdata
);

  phase_e                phase_q, phase_d;
  logic [IdxWidth-1:0]   idx_q, idx_d;
  logic [OutWidth-1:0]   store_q;
  logic [OutWidth-1:0]   out_data_q;
  logic                  out_valid_q;
  logic                  in_fire;
  logic                  shift_en;
  logic                  emit;

  // Stall input only when a result may be due and the output slot is blocked
  assign s_axis_tready = !((phase_q == PH_TRL2) && out_valid_q && !m_axis_tready);
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  // Phase update for one accepted byte
  always_comb begin
    phase_d  = phase_q;
    idx_d    = idx_q;
    shift_en = 1'b0;
    emit     = 1'b0;
    if (in_fire) begin
      unique case (phase_q)
        PH_HUNT: begin
          phase_d = (s_axis_tdata == HDR_FIRST) ? PH_HDR : PH_HUNT;
        end
        PH_HDR: begin
          if (s_axis_tdata == HDR_SECOND) begin
            idx_d   = '0;
            phase_d = PH_PAYLOAD;
          end else if (s_axis_tdata != HDR_FIRST) begin
            phase_d = PH_HUNT;
          end
        end
        PH_PAYLOAD: begin
          shift_en = (idx_q <= LastIdx);
          if (idx_q >= LastIdx) begin
            idx_d   = '0;
            phase_d = PH_TRL1;
          end else begin
            idx_d = idx_q + 1'b1;
          end
        end
        PH_TRL1: begin
          phase_d = (s_axis_tdata == TRL_FIRST) ? PH_TRL2 : PH_HUNT;
        end
        PH_TRL2: begin
          emit    = (s_axis_tdata == TRL_SECOND);
          phase_d = PH_HUNT;
        end
        default: begin
          phase_d = PH_HUNT;
        end
      endcase
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_HUNT;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
      idx_q   <= idx_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload shift line: oldest byte ends up in the lowest bits
  always_ff @(posedge clk_i) begin
    if (shift_en) begin
      store_q <= {s_axis_tdata, store_q[OutWidth-1:ByteWidth]};
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_data_q <= store_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

// ----- hw/rtl/pfd_checker.sv -----
// Port-level checker for pose_frame_deframer, attached by bind.
// Depends on pfd_pkg.
module pfd_checker
  import pfd_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                s_axis_tvalid,
  input logic                s_axis_tready,
  input logic [7:0]          s_axis_tdata,
  input logic                m_axis_tvalid,
  input logic                m_axis_tready,
  input logic [OutWidth-1:0] m_axis_tdata
);

  logic in_fire;
  logic out_fire;

  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign out_fire = m_axis_tvalid && m_axis_tready;

  // Hold a stalled result beat
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("result beat changed while stalled");

  // A new result follows only a closing trailer byte
  a_out_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!m_axis_tvalid || m_axis_tready) ##1 m_axis_tvalid
      |-> $past(in_fire && (s_axis_tdata == TRL_SECOND)))
    else $error("result beat without a closing trailer byte");

  // No result appears without an input beat
  a_out_no_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_fire && !in_fire) |=> !m_axis_tvalid)
    else $error("result beat repeated without input");

  // Input stalls only behind a blocked result
  a_in_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
    else $error("input stalled with a free output");

endmodule

bind pose_frame_deframer pfd_checker u_pfd_checker (.*);
